// ===== rtl/core/lca_pkg.sv =====
// Shared constants, types and codes of the life-like cellular automaton block.
package lca_pkg;

  // Fixed field widths of the stream items.
  localparam int ROW_W    = 64;
  localparam int IDX_W    = 6;
  localparam int TDATA_W  = 72;
  localparam int GRID_CAP = 64;

  // Configuration registers.
  localparam int RULE_W    = 18;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RULE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [RULE_W-1:0] RULE_RESET   = 18'd144;
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = 7'd64;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 7'd64;

  // Default sizes of the grid storage.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Neighbour count 0..8.
  localparam int NBR_CNT_W = 4;

  // Input item kinds carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Per-count cell action taken from the rule register.
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_KEEP   = 2'd1,
    ACT_SET    = 2'd2,
    ACT_INVERT = 2'd3
  } act_e;

endpackage

// ===== rtl/core/life_like_ca_generation.sv =====
// Top level of the life-like cellular automaton generation block.
//
// The block keeps a toroidal grid of cells, one row per memory word. Input
// items arrive on the s_axis channel: tuser selects the kind, 0 loads the
// row in tdata into the grid and 1 computes one generation. A load gives no
// result; a load whose row index is not below the grid height in use is
// dropped. A step reads the last row and row 0 first through the single read
// port of the grid memory, then sweeps the rows in order, one row per cycle
// while m_axis accepts, writing each new row back in place and sending it on
// m_axis with tlast on the final row. Each row is computed by one lane per
// column working side by side. The block takes one item at a time:
// s_axis_tready is high only while no step is in progress, and a finished
// row waits in the output register, so a stalled receiver simply holds the
// sweep. Configuration registers (rule, width, height) are written through
// the cfg port; the user must do so only while the block is idle, as the
// block itself does not enforce it. Reset clears the grid to all dead through
// per-row valid bits, with no clearing pass, and loads the rule register with
// the Conway rule.
module life_like_ca_generation #(
  parameter int MAX_WIDTH  = lca_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lca_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [lca_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lca_pkg::RULE_W-1:0]    cfg_data_i,
  // Input items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lca_pkg::TDATA_W-1:0]   s_axis_tdata,  // row_index, row_bits, zero pad
  input  logic                          s_axis_tuser,  // opcode
  // Result items.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lca_pkg::TDATA_W-1:0]   m_axis_tdata,  // out_row_index, out_row_bits, zero pad
  output logic                          m_axis_tlast   // last_row
);
  import lca_pkg::*;

  // Rows actually stored, at most the grid cap; the effective height is clamped to it.
  localparam int DEPTH = (MAX_HEIGHT > GRID_CAP) ? GRID_CAP : MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW    = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ABOVE = 2'd1;
  localparam logic [1:0] ST_FIRST = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  // Configuration registers.
  logic [RULE_W-1:0] rule_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;

  // Sequencer and row pipeline.
  logic [1:0]           state_q, state_d;
  logic [HW-1:0]        y_q, y_d;
  logic [MAX_WIDTH-1:0] above_q, above_d;
  logic [MAX_WIDTH-1:0] cur_q, cur_d;
  logic [MAX_WIDTH-1:0] first_q, first_d;
  logic [DEPTH-1:0]     row_valid_q;
  logic                 rd_valid_q;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [IDX_W-1:0]     out_idx_q;
  logic [MAX_WIDTH-1:0] out_bits_q;
  logic                 out_last_q;

  // Effective dimensions and masks.
  logic [DIM_W-1:0]     w_eff;
  logic [DIM_W-1:0]     h_eff;
  logic [DIM_W-1:0]     h_last;
  logic [MAX_WIDTH-1:0] mask;

  // Memory port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MAX_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [MAX_WIDTH-1:0] ram_rdata;
  logic [MAX_WIDTH-1:0] rd_row;

  logic                 in_acc;
  logic [IDX_W-1:0]     in_idx;
  logic [MAX_WIDTH-1:0] in_bits;
  logic [MAX_WIDTH-1:0] below;
  logic [MAX_WIDTH-1:0] next_row;
  logic [DIM_W-1:0]     y_ext;
  logic                 is_last;
  logic                 run_adv;

  // Zero means one, and anything beyond the storage means the storage size.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(DEPTH)) begin
      h_eff = DIM_W'(DEPTH);
    end else begin
      h_eff = height_q;
    end
  end

  assign h_last = h_eff - DIM_W'(1);

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_mask
    assign mask[x] = (DIM_W'(x) < w_eff);
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q   <= RULE_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RULE:   rule_q   <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_bits = s_axis_tdata[IDX_W +: MAX_WIDTH];

  // A row that was never written since reset reads as all dead.
  assign rd_row = rd_valid_q ? (ram_rdata & mask) : '0;

  assign y_ext   = DIM_W'(y_q);
  assign is_last = (y_ext == h_last);
  assign below   = is_last ? first_q : rd_row;
  assign run_adv = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);

  lca_row_engine #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_engine (
    .above_i (above_q),
    .cur_i   (cur_q),
    .below_i (below),
    .mask_i  (mask),
    .width_i (w_eff),
    .rule_i  (rule_q),
    .next_o  (next_row)
  );

  // Sequencer: the last row and row 0 are fetched before the sweep; during the
  // sweep the row two below the current one is fetched while it is computed.
  always_comb begin
    state_d   = state_q;
    y_d       = y_q;
    above_d   = above_q;
    cur_d     = cur_q;
    first_d   = first_q;
    ram_we    = 1'b0;
    ram_waddr = in_idx[AW-1:0];
    ram_wdata = in_bits & mask;
    ram_re    = 1'b0;
    ram_raddr = h_last[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_STEP) begin
            ram_re  = 1'b1;
            state_d = ST_ABOVE;
          end else if (DIM_W'(in_idx) < h_eff) begin
            ram_we = 1'b1;
          end
        end
      end
      ST_ABOVE: begin
        above_d   = rd_row;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = ST_FIRST;
      end
      ST_FIRST: begin
        cur_d     = rd_row;
        first_d   = rd_row;
        y_d       = '0;
        ram_re    = (h_eff > DIM_W'(1));
        ram_raddr = AW'(1);
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (run_adv) begin
          ram_we    = 1'b1;
          ram_waddr = y_q[AW-1:0];
          ram_wdata = next_row;
          above_d   = cur_q;
          cur_d     = below;
          ram_re    = ((y_ext + DIM_W'(2)) < h_eff);
          ram_raddr = AW'(y_q + HW'(2));
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            y_d = y_q + HW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (run_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      y_q         <= '0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= row_valid_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    cur_q   <= cur_d;
    first_q <= first_d;
    if (run_adv) begin
      out_idx_q  <= IDX_W'(y_q);
      out_bits_q <= next_row;
      out_last_q <= is_last;
    end
  end

  lca_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(TDATA_W - IDX_W - ROW_W)'(0), ROW_W'(out_bits_q), out_idx_q};

  // The final row of a generation carries the last row number in use.
  a_last_row_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (DIM_W'(out_idx_q) == h_last))
    else $error("tlast on a row other than the last one in use");

  // The in-place write never hits the row being fetched in the same cycle.
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid write and read at the same row");

  // The sweep row counter stays inside the grid height in use.
  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (y_ext < h_eff))
    else $error("sweep row beyond the grid height");

  // A row is produced only while a sweep is running.
  a_out_from_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_RUN))
    else $error("result row raised outside a sweep");

endmodule

// ===== rtl/core/lca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lca_ram #(
  parameter int WIDTH = lca_pkg::ROW_W,
  parameter int DEPTH = lca_pkg::GRID_CAP,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lca_lane.sv =====
// One cell lane: counts the eight neighbours and applies the rule action.
module lca_lane (
  input  logic [7:0]                nbr_i,
  input  logic                      self_i,
  input  logic [lca_pkg::RULE_W-1:0] rule_i,
  output logic                      next_o
);
  import lca_pkg::*;

  logic [NBR_CNT_W-1:0] cnt;
  logic [RULE_W-1:0]    rule_sh;
  act_e                 act;

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + NBR_CNT_W'(nbr_i[k]);
    end
  end

  assign rule_sh = rule_i >> {cnt, 1'b0};
  assign act     = act_e'(rule_sh[1:0]);

  always_comb begin
    case (act)
      ACT_CLEAR:  next_o = 1'b0;
      ACT_KEEP:   next_o = self_i;
      ACT_SET:    next_o = 1'b1;
      ACT_INVERT: next_o = ~self_i;
      default:    next_o = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/lca_row_engine.sv =====
// Row engine: one lane per column with horizontal wrap, merged into the new row.
module lca_row_engine #(
  parameter int MAX_WIDTH = lca_pkg::DEF_MAX_WIDTH
) (
  input  logic [MAX_WIDTH-1:0]       above_i,
  input  logic [MAX_WIDTH-1:0]       cur_i,
  input  logic [MAX_WIDTH-1:0]       below_i,
  input  logic [MAX_WIDTH-1:0]       mask_i,
  input  logic [lca_pkg::DIM_W-1:0]  width_i,
  input  logic [lca_pkg::RULE_W-1:0] rule_i,
  output logic [MAX_WIDTH-1:0]       next_o
);
  import lca_pkg::*;

  localparam int WIDX = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [DIM_W-1:0]     w_last;
  logic [WIDX-1:0]      last_col;
  logic                 above_last;
  logic                 cur_last;
  logic                 below_last;
  logic [MAX_WIDTH-1:0] lane_bits;

  assign w_last     = width_i - DIM_W'(1);
  assign last_col   = w_last[WIDX-1:0];
  assign above_last = above_i[last_col];
  assign cur_last   = cur_i[last_col];
  assign below_last = below_i[last_col];

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
    logic       al, cl, bl;
    logic       ar, cr, br;
    logic [7:0] nbr;

    // Left neighbour wraps to the last column in use.
    if (x == 0) begin : g_left_wrap
      assign al = above_last;
      assign cl = cur_last;
      assign bl = below_last;
    end else begin : g_left
      assign al = above_i[x-1];
      assign cl = cur_i[x-1];
      assign bl = below_i[x-1];
    end

    // Right neighbour wraps to column zero on the last column in use.
    if (x == MAX_WIDTH - 1) begin : g_right_wrap
      assign ar = above_i[0];
      assign cr = cur_i[0];
      assign br = below_i[0];
    end else begin : g_right
      logic at_end;
      assign at_end = (last_col == WIDX'(x));
      assign ar = at_end ? above_i[0] : above_i[x+1];
      assign cr = at_end ? cur_i[0]   : cur_i[x+1];
      assign br = at_end ? below_i[0] : below_i[x+1];
    end

    assign nbr = {al, above_i[x], ar, cl, cr, bl, below_i[x], br};

    lca_lane u_lane (
      .nbr_i  (nbr),
      .self_i (cur_i[x]),
      .rule_i (rule_i),
      .next_o (lane_bits[x])
    );
  end

  // Merge the lanes into one row; columns beyond the width read as dead.
  assign next_o = lane_bits & mask_i;

endmodule
